// ===== sv/lsm_pkg.sv =====
// Shared definitions for the LED strip level meter encoder.
// Holds strip size, mode codes, and the command word passed from the front end to the back end.
// No dependencies.
`default_nettype none

package lsm_pkg;

    localparam int LED_COUNT  = 40;
    localparam int IDX_W      = 6;
    localparam int CODE_W     = 24;
    localparam int MODE_W     = 3;
    localparam int ENERGY_W   = 16;
    localparam int SRC_W      = 2;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // override register codes; anything else behaves as auto
    localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLUE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BREATH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REACT  = 3'd4;

    // source codes
    localparam logic [SRC_W-1:0] SRC_AUX = 2'd0;
    localparam logic [SRC_W-1:0] SRC_BT  = 2'd1;

    typedef enum logic [2:0] {
        KIND_FLAT = 3'b001,
        KIND_AUX  = 3'b010,
        KIND_BT   = 3'b100
    } kind_t;

    // one frame job: what pattern to draw and with what color
    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] level;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ===== sv/led_strip_level_meter_encoder.sv =====
// Top level of the LED strip level meter encoder.
// Instantiates lsm_front, lsm_cmd_fifo and lsm_back; depends on lsm_pkg.
//
// Each frame request pushed in yields either a full frame of 40 words (one per LED, index 0
// first, last_led on index 39) or nothing at all. Modes off, steady blue and breathing always
// give a frame; auto and react give one only when refresh_due is set and the source is aux or
// bluetooth. Each word carries the green, red and blue bytes as 24-bit line codes (one -> 110,
// zero -> 100, MSB first), ready to shift out to the strip. A request is classified in the
// cycle it is accepted and parked in a two-entry command queue; the back end walks the strip
// one LED per clock while pop keeps the output register free, and consecutive frames run
// back to back with no gap. When the back end is idle, the first word of a frame passes the
// queue entry, the command register and the output register before it appears. A new request
// is taken while a frame is still being walked, as long as the queue is not full; full rises
// when the queue holds two frames. Requests that draw nothing finish at acceptance. The
// breathing phase steps at acceptance of a breathing-mode request with breath_advance set.
// Write override_mode only while the block is idle (queue empty, no word pending).
`default_nettype none

module led_strip_level_meter_encoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         override_mode_we,
    input  wire logic [lsm_pkg::MODE_W-1:0]   override_mode_wdata,
    input  wire logic                         push,
    output      logic                         full,
    input  wire logic                         breath_advance,
    input  wire logic                         refresh_due,
    input  wire logic [lsm_pkg::SRC_W-1:0]    source,
    input  wire logic [lsm_pkg::ENERGY_W-1:0] energy,
    input  wire logic                         pop,
    output      logic                         empty,
    output      logic [lsm_pkg::IDX_W-1:0]    led_index,
    output      logic [lsm_pkg::CODE_W-1:0]   green_code,
    output      logic [lsm_pkg::CODE_W-1:0]   red_code,
    output      logic [lsm_pkg::CODE_W-1:0]   blue_code,
    output      logic                         last_led
);
    import lsm_pkg::*;

    fifo_stat_t fifo_stat;
    cmd_t       front_cmd;
    cmd_t       head_cmd;
    logic       cmd_push;
    logic       head_take;
    logic       req_accept;
    logic       out_valid;

    assign full       = fifo_stat.full;
    assign req_accept = push && !fifo_stat.full;
    assign empty      = !out_valid;

    // classify request, keep mode and breathing phase
    lsm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode_we        (override_mode_we),
        .mode_wdata     (override_mode_wdata),
        .req_accept     (req_accept),
        .breath_advance (breath_advance),
        .refresh_due    (refresh_due),
        .source         (source),
        .energy         (energy),
        .cmd_push       (cmd_push),
        .cmd            (front_cmd)
    );

    // decouples request side from LED walk
    lsm_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (front_cmd),
        .rd_en  (head_take),
        .rd_cmd (head_cmd),
        .stat   (fifo_stat)
    );

    // one LED word per cycle into the output register, while pop keeps it free
    lsm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (fifo_stat.valid),
        .head_take  (head_take),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_index  (led_index),
        .out_green  (green_code),
        .out_red    (red_code),
        .out_blue   (blue_code),
        .out_last   (last_led)
    );

    // a command is only produced for an accepted request, so the queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_stat.full)
        else $error("command pushed into full queue");

    // last_led marks exactly the final strip position
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_led == (led_index == IDX_W'(LED_COUNT - 1))))
        else $error("last_led does not match final index");

    // after a non-final word is taken the next LED follows at once
    a_next_led: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_led) |=>
            (!empty && led_index == IDX_W'($past(led_index) + 1'b1)))
        else $error("frame walk stalled or skipped an LED");

    // a waiting word holds still until it is taken
    a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(led_index) && $stable(green_code) && $stable(red_code)
                && $stable(blue_code) && $stable(last_led)))
        else $error("waiting word changed before it was taken");

endmodule

`default_nettype wire

// ===== sv/lsm_front.sv =====
// Front end: takes frame requests, holds the override register and breathing phase,
// and turns each request into a frame command. Depends on lsm_pkg.
`default_nettype none

module lsm_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         mode_we,
    input  wire logic [lsm_pkg::MODE_W-1:0]   mode_wdata,
    input  wire logic                         req_accept,
    input  wire logic                         breath_advance,
    input  wire logic                         refresh_due,
    input  wire logic [lsm_pkg::SRC_W-1:0]    source,
    input  wire logic [lsm_pkg::ENERGY_W-1:0] energy,
    output      logic                         cmd_push,
    output      lsm_pkg::cmd_t                cmd
);
    import lsm_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [7:0]        phase_reg;
    logic [7:0]        phase_next;
    logic [7:0]        phase_inc;
    logic [7:0]        breath_blue;
    logic [IDX_W-1:0]  aux_level;
    logic [IDX_W-1:0]  bt_level;
    logic [7:0]        hue;
    logic [23:0]       bt_rgb;

    // hue wheel in three thirds, each channel ramps in steps of three
    function automatic logic [23:0] hue_rgb(input logic [7:0] h);
        logic [9:0] h3;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        h3 = 10'(h) * 10'd3;
        if (h < 8'd85) begin
            r = 8'd0;
            g = h3[7:0];
            b = 8'd255 - h3[7:0];
        end else if (h < 8'd170) begin
            r = 8'(h3 - 10'd255);
            g = 8'd255;
            b = 8'd0;
        end else begin
            r = 8'd255;
            g = 8'(10'd765 - h3);
            b = 8'(h3 - 10'd510);
        end
        return {r, g, b};
    endfunction

    always_comb
    begin
        if      (energy < 16'd300)   aux_level = 6'd0;
        else if (energy < 16'd1000)  aux_level = 6'd5;
        else if (energy < 16'd2500)  aux_level = 6'd10;
        else if (energy < 16'd5000)  aux_level = 6'd15;
        else if (energy < 16'd8000)  aux_level = 6'd20;
        else if (energy < 16'd12000) aux_level = 6'd25;
        else if (energy < 16'd18000) aux_level = 6'd30;
        else if (energy < 16'd25000) aux_level = 6'd35;
        else                         aux_level = IDX_W'(LED_COUNT);

        if      (energy < 16'd300)   bt_level = 6'd0;
        else if (energy < 16'd4000)  bt_level = 6'd2;
        else if (energy < 16'd8000)  bt_level = 6'd5;
        else if (energy < 16'd12000) bt_level = 6'd8;
        else if (energy < 16'd18000) bt_level = 6'd11;
        else if (energy < 16'd25000) bt_level = 6'd14;
        else if (energy < 16'd35000) bt_level = 6'd17;
        else                         bt_level = 6'd20;

        if      (energy < 16'd1200)  hue = 8'd32;
        else if (energy < 16'd3000)  hue = 8'd64;
        else if (energy < 16'd6000)  hue = 8'd96;
        else if (energy < 16'd10000) hue = 8'd128;
        else if (energy < 16'd16000) hue = 8'd160;
        else if (energy < 16'd25000) hue = 8'd192;
        else if (energy < 16'd38000) hue = 8'd224;
        else                         hue = 8'd255;
    end

    assign bt_rgb = hue_rgb(hue);

    // phase steps before use; triangle: 2p rising, 2(255-p) falling
    assign phase_inc   = phase_reg + {7'd0, breath_advance};
    assign breath_blue = phase_inc[7] ? {~phase_inc[6:0], 1'b0} : {phase_inc[6:0], 1'b0};

    always_comb
    begin
        phase_next = phase_reg;
        cmd_push   = 1'b0;
        cmd        = '{kind: KIND_FLAT, level: '0, red: '0, green: '0, blue: '0};
        unique case (mode_reg)
            MODE_OFF:
            begin
                cmd_push = req_accept;
            end
            MODE_BLUE:
            begin
                cmd_push = req_accept;
                cmd.blue = 8'd64;
            end
            MODE_BREATH:
            begin
                cmd_push = req_accept;
                cmd.blue = breath_blue;
                if (req_accept)
                    phase_next = phase_inc;
            end
            default:
            begin
                // auto and react: only on refresh, only for aux or bluetooth
                if (source == SRC_AUX) begin
                    cmd_push  = req_accept && refresh_due;
                    cmd.kind  = KIND_AUX;
                    cmd.level = aux_level;
                end else if (source == SRC_BT) begin
                    cmd_push  = req_accept && refresh_due;
                    cmd.kind  = KIND_BT;
                    cmd.level = bt_level;
                    {cmd.red, cmd.green, cmd.blue} = bt_rgb;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_AUTO;
            phase_reg <= 8'd0;
        end else begin
            if (mode_we)
                mode_reg <= mode_wdata;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lsm_cmd_fifo.sv =====
// Short command queue between front end and back end.
// Register-based ring of frame commands. Depends on lsm_pkg.
`default_nettype none

module lsm_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire lsm_pkg::cmd_t wr_cmd,
    input  wire logic          rd_en,
    output      lsm_pkg::cmd_t rd_cmd,
    output      lsm_pkg::fifo_stat_t stat
);
    import lsm_pkg::*;

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign stat.full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign rd_cmd     = entry_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && stat.valid;

    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr)
                wr_ptr_reg <= ptr_step(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= ptr_step(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lsm_back.sv =====
// Back end: for each frame command, walks the strip one LED per cycle unless pop stalls,
// picks the color, line-codes it into the output register. Depends on lsm_pkg.
`default_nettype none

module lsm_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lsm_pkg::cmd_t             head_cmd,
    input  wire logic                      head_valid,
    output      logic                      head_take,
    input  wire logic                      pop,
    output      logic                      out_valid,
    output      logic [lsm_pkg::IDX_W-1:0]  out_index,
    output      logic [lsm_pkg::CODE_W-1:0] out_green,
    output      logic [lsm_pkg::CODE_W-1:0] out_red,
    output      logic [lsm_pkg::CODE_W-1:0] out_blue,
    output      logic                      out_last
);
    import lsm_pkg::*;

    localparam int HALF = LED_COUNT / 2;

    typedef logic [LED_COUNT-1:0][15:0] aux_tab_t;

    // bar color ramp by position; {red, green}, green wraps mod 256 at the top
    function automatic aux_tab_t build_aux_table();
        aux_tab_t tab;
        int       pos;
        int       r;
        int       g;
        for (int i = 0; i < LED_COUNT; i++) begin
            pos = ((i + 1) * 256) / LED_COUNT;
            if (pos < 85) begin
                r = 0;
                g = pos * 3;
            end else if (pos < 170) begin
                r = (pos - 85) * 3;
                g = 255;
            end else begin
                r = 255;
                g = (255 - (pos - 170) * 3) & 255;
            end
            tab[i] = {8'(r), 8'(g)};
        end
        return tab;
    endfunction

    localparam aux_tab_t AUX_TABLE = build_aux_table();

    // 1 -> 110, 0 -> 100, MSB first
    function automatic logic [CODE_W-1:0] line_code(input logic [7:0] v);
        logic [CODE_W-1:0] c;
        for (int k = 0; k < 8; k++)
            c[3*k +: 3] = v[k] ? 3'b110 : 3'b100;
        return c;
    endfunction

    cmd_t             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [CODE_W-1:0] out_green_reg;
    logic [CODE_W-1:0] out_red_reg;
    logic [CODE_W-1:0] out_blue_reg;
    logic             out_last_reg;

    logic             advance;
    logic             at_last;
    logic [IDX_W-1:0] bt_dist;
    logic             lit;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;

    assign advance   = busy_reg && (!out_valid_reg || pop);
    assign at_last   = (idx_reg == IDX_W'(LED_COUNT - 1));
    assign head_take = head_valid && (!busy_reg || (advance && at_last));

    // distance from the center pair, for the center-out spread
    assign bt_dist = (idx_reg < IDX_W'(HALF)) ? IDX_W'(HALF - 1) - idx_reg
                                             : idx_reg - IDX_W'(HALF);

    always_comb
    begin
        lit   = 1'b1;
        red   = cmd_reg.red;
        green = cmd_reg.green;
        blue  = cmd_reg.blue;
        unique case (cmd_reg.kind)
            KIND_FLAT: ;
            KIND_AUX:
            begin
                lit           = idx_reg < cmd_reg.level;
                {red, green}  = AUX_TABLE[idx_reg];
                blue          = 8'd0;
            end
            KIND_BT:
            begin
                lit = bt_dist < cmd_reg.level;
            end
            default:
            begin
                lit = 1'b0;
            end
        endcase
        if (!lit) begin
            red   = 8'd0;
            green = 8'd0;
            blue  = 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
            cmd_reg <= head_cmd;
        if (advance) begin
            out_index_reg <= idx_reg;
            out_green_reg <= line_code(green);
            out_red_reg   <= line_code(red);
            out_blue_reg  <= line_code(blue);
            out_last_reg  <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (head_take) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (advance) begin
                if (at_last)
                    busy_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_green = out_green_reg;
    assign out_red   = out_red_reg;
    assign out_blue  = out_blue_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/lsm_tb_pkg.sv =====
// Frame predictor and word checker for the LED strip level meter encoder testbench.
// Depends on lsm_pkg for strip size, field widths, mode and source codes.

package lsm_tb_pkg;
    import lsm_pkg::*;

    // mode values with no function of their own; they fall back to auto
    localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam logic [SRC_W-1:0] SRC_OTHER = 2'd2;
    localparam logic [SRC_W-1:0] SRC_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [CODE_W-1:0] green;
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] blue;
        logic              last;
    } led_word_t;

    // one -> 110, zero -> 100, MSB first
    function automatic logic [CODE_W-1:0] line_code(input logic [7:0] value);
        logic [CODE_W-1:0] code;
        int                k;
        code = '0;
        for (k = 7; k >= 0; k--)
        begin
            code = {code[CODE_W-4:0], value[k] ? 3'b110 : 3'b100};
        end
        return code;
    endfunction

    class frame_checker;
        logic [MODE_W-1:0] mode;
        logic [7:0]        phase;
        led_word_t         frame_words[$];
        int unsigned       errors;

        function new();
            mode   = MODE_AUTO;
            phase  = '0;
            errors = 0;
        endfunction

        function void set_mode(input logic [MODE_W-1:0] value);
            mode = value;
        endfunction

        function int pending();
            return frame_words.size();
        endfunction

        function void add_led(input int i, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
            led_word_t w;
            w.index = i[IDX_W-1:0];
            w.green = line_code(g);
            w.red   = line_code(r);
            w.blue  = line_code(b);
            w.last  = (i == LED_COUNT - 1);
            frame_words.push_back(w);
        endfunction

        function void add_flat(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
            int i;
            for (i = 0; i < LED_COUNT; i++)
            begin
                add_led(i, r, g, b);
            end
        endfunction

        // energy bar from LED 0 up, green -> yellow -> red along the strip
        function void add_aux_bar(input logic [ENERGY_W-1:0] e);
            int level, i, pos, top_green;
            logic [7:0] r, g;
            if (e < 300)        level = 0;
            else if (e < 1000)  level = 5;
            else if (e < 2500)  level = 10;
            else if (e < 5000)  level = 15;
            else if (e < 8000)  level = 20;
            else if (e < 12000) level = 25;
            else if (e < 18000) level = 30;
            else if (e < 25000) level = 35;
            else                level = LED_COUNT;
            for (i = 0; i < LED_COUNT; i++)
            begin
                r = '0;
                g = '0;
                if (i < level)
                begin
                    pos = (i + 1) * 256 / LED_COUNT;
                    if (pos < 85)
                    begin
                        g = 8'(pos * 3);
                    end
                    else if (pos < 170)
                    begin
                        r = 8'((pos - 85) * 3);
                        g = 8'd255;
                    end
                    else
                    begin
                        // goes negative at the far end; keep the low byte
                        top_green = 255 - (pos - 170) * 3;
                        r = 8'd255;
                        g = top_green[7:0];
                    end
                end
                add_led(i, r, g, 8'd0);
            end
        endfunction

        // spread out from the middle pair, one hue for the whole frame
        function void add_bt_spread(input logic [ENERGY_W-1:0] e);
            int level, hue, i, cr, cg, cb;
            bit lit;
            if (e < 300)        level = 0;
            else if (e < 4000)  level = 2;
            else if (e < 8000)  level = 5;
            else if (e < 12000) level = 8;
            else if (e < 18000) level = 11;
            else if (e < 25000) level = 14;
            else if (e < 35000) level = 17;
            else                level = 20;
            if (e < 1200)       hue = 32;
            else if (e < 3000)  hue = 64;
            else if (e < 6000)  hue = 96;
            else if (e < 10000) hue = 128;
            else if (e < 16000) hue = 160;
            else if (e < 25000) hue = 192;
            else if (e < 38000) hue = 224;
            else                hue = 255;
            if (hue < 85)
            begin
                cr = 0;
                cg = hue * 3;
                cb = 255 - hue * 3;
            end
            else if (hue < 170)
            begin
                cr = (hue - 85) * 3;
                cg = 255;
                cb = 0;
            end
            else
            begin
                cr = 255;
                cg = (255 - hue) * 3;
                cb = (hue - 170) * 3;
            end
            for (i = 0; i < LED_COUNT; i++)
            begin
                lit = (i < LED_COUNT / 2 && LED_COUNT / 2 - 1 - i < level) ||
                      (i >= LED_COUNT / 2 && i - LED_COUNT / 2 < level);
                if (lit)
                    add_led(i, cr[7:0], cg[7:0], cb[7:0]);
                else
                    add_led(i, 8'd0, 8'd0, 8'd0);
            end
        endfunction

        // accepted request: queue up the frame it should produce, if any
        function void note_request(input logic adv, input logic due,
                                   input logic [SRC_W-1:0] src,
                                   input logic [ENERGY_W-1:0] e);
            logic [7:0] breath_blue;
            case (mode)
                MODE_OFF:  add_flat(8'd0, 8'd0, 8'd0);
                MODE_BLUE: add_flat(8'd0, 8'd0, 8'd64);
                MODE_BREATH:
                begin
                    if (adv)
                        phase = phase + 8'd1;
                    if (phase < 8'd128)
                        breath_blue = {phase[6:0], 1'b0};
                    else
                        breath_blue = {~phase[6:0], 1'b0};
                    add_flat(8'd0, 8'd0, breath_blue);
                end
                default:
                begin
                    if (due && src == SRC_AUX)
                        add_aux_bar(e);
                    else if (due && src == SRC_BT)
                        add_bt_spread(e);
                end
            endcase
        endfunction

        task log_mismatch(input string field, input int at, input logic [31:0] want,
                          input logic [31:0] got);
            errors++;
            $display("mismatch at LED %0d, %s: expected %h, got %h", at, field, want, got);
        endtask

        task check_word(input logic [IDX_W-1:0] index, input logic [CODE_W-1:0] green,
                        input logic [CODE_W-1:0] red, input logic [CODE_W-1:0] blue,
                        input logic last);
            led_word_t w;
            if (frame_words.size() == 0)
            begin
                log_mismatch("word with nothing expected", index, '0, index);
                return;
            end
            w = frame_words.pop_front();
            if (index !== w.index) log_mismatch("led_index", w.index, w.index, index);
            if (green !== w.green) log_mismatch("green_code", w.index, w.green, green);
            if (red !== w.red)     log_mismatch("red_code", w.index, w.red, red);
            if (blue !== w.blue)   log_mismatch("blue_code", w.index, w.blue, blue);
            if (last !== w.last)   log_mismatch("last_led", w.index, w.last, last);
        endtask
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for the LED strip level meter encoder.
// Drives frame requests and mode writes, checks every LED word; depends on lsm_pkg, lsm_tb_pkg.

module tb;
    import lsm_pkg::*;
    import lsm_tb_pkg::*;

    // a first word passes the queue, command and output registers; this leaves ample margin
    localparam int SETTLE_CYCLES   = 8;
    // far beyond the slowest legal run (a few hundred frames under heavy stall)
    localparam int WATCHDOG_CYCLES = 1000000;

    logic                clk;
    logic                rst_n;
    logic                override_mode_we;
    logic [MODE_W-1:0]   override_mode_wdata;
    logic                push;
    logic                full;
    logic                breath_advance;
    logic                refresh_due;
    logic [SRC_W-1:0]    source;
    logic [ENERGY_W-1:0] energy;
    logic                pop;
    logic                empty;
    logic [IDX_W-1:0]    led_index;
    logic [CODE_W-1:0]   green_code;
    logic [CODE_W-1:0]   red_code;
    logic [CODE_W-1:0]   blue_code;
    logic                last_led;

    // percent of cycles the request side sits idle / the word side refuses to pop
    int idle_pct;
    int stall_pct;

    frame_checker sb;

    led_strip_level_meter_encoder u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .override_mode_we    (override_mode_we),
        .override_mode_wdata (override_mode_wdata),
        .push                (push),
        .full                (full),
        .breath_advance      (breath_advance),
        .refresh_due         (refresh_due),
        .source              (source),
        .energy              (energy),
        .pop                 (pop),
        .empty               (empty),
        .led_index           (led_index),
        .green_code          (green_code),
        .red_code            (red_code),
        .blue_code           (blue_code),
        .last_led            (last_led)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Word side: pop is redrawn every falling edge so stalls land on any
    // LED of a frame, including the last one and the gap between frames.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Every word handed over is compared against the oldest predicted one.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_word(led_index, green_code, red_code, blue_code, last_led);
    end

    // Half the time uniform energy, otherwise a step of one of the level or hue
    // ladders give or take one, so every threshold is hit from both sides.
    function automatic logic [ENERGY_W-1:0] pick_energy();
        int bound;
        if ($urandom_range(0, 1) == 0)
            return ENERGY_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 15))
            0:       bound = 300;
            1:       bound = 1000;
            2:       bound = 1200;
            3:       bound = 2500;
            4:       bound = 3000;
            5:       bound = 4000;
            6:       bound = 5000;
            7:       bound = 6000;
            8:       bound = 8000;
            9:       bound = 10000;
            10:      bound = 12000;
            11:      bound = 16000;
            12:      bound = 18000;
            13:      bound = 25000;
            14:      bound = 35000;
            default: bound = 38000;
        endcase
        return ENERGY_W'(bound + $urandom_range(0, 2) - 1);
    endfunction

    // Mode register write; only called with the block drained. Starts and
    // ends on a falling edge.
    task automatic write_mode(input logic [MODE_W-1:0] value);
        override_mode_we    <= 1'b1;
        override_mode_wdata <= value;
        @(negedge clk);
        override_mode_we <= 1'b0;
        sb.set_mode(value);
    endtask

    // One frame request. Enters on a falling edge, leaves on the falling edge
    // after acceptance with push still high, so back-to-back requests never
    // drop and re-raise push in the same step.
    task automatic send_request(input logic adv, input logic due,
                                input logic [SRC_W-1:0] src,
                                input logic [ENERGY_W-1:0] e);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push           <= 1'b1;
        breath_advance <= adv;
        refresh_due    <= due;
        source         <= src;
        energy         <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(adv, due, src, e);
        @(negedge clk);
    endtask

    // Hold off requests until every predicted word is out, then let any
    // request that draws nothing settle before touching the mode register.
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_random(input int count);
        int               k;
        int               pick;
        logic             adv;
        logic             due;
        logic [SRC_W-1:0] src;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                src = SRC_AUX;
            else if (pick < 18)
                src = SRC_BT;
            else if (pick == 18)
                src = SRC_OTHER;
            else
                src = SRC_SPARE;
            due = ($urandom_range(0, 99) < 85);
            // breathing needs long runs of ticks to climb well past mid-scale
            if (sb.mode == MODE_BREATH)
                adv = ($urandom_range(0, 49) != 0);
            else
                adv = 1'($urandom_range(0, 1));
            send_request(adv, due, src, pick_energy());
        end
    endtask

    initial
    begin
        int                p;
        logic [MODE_W-1:0] m;
        sb                  = new();
        rst_n               = 1'b0;
        override_mode_we    = 1'b0;
        override_mode_wdata = MODE_AUTO;
        push                = 1'b0;
        breath_advance      = 1'b0;
        refresh_due         = 1'b0;
        source              = SRC_AUX;
        energy              = '0;
        idle_pct            = 0;
        stall_pct           = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, no idling. Mode is still the reset value (auto).
        // Aux bar: empty, just under/at the first step, at the full step, full.
        send_request(1'b0, 1'b1, SRC_AUX, 16'd0);
        send_request(1'b1, 1'b1, SRC_AUX, 16'd299);
        send_request(1'b0, 1'b1, SRC_AUX, 16'd300);
        send_request(1'b0, 1'b1, SRC_AUX, 16'd25000);
        send_request(1'b1, 1'b1, SRC_AUX, 16'hFFFF);
        // bluetooth spread: dark, hue steps, widest spread, top hue
        send_request(1'b0, 1'b1, SRC_BT, 16'd0);
        send_request(1'b0, 1'b1, SRC_BT, 16'd1199);
        send_request(1'b1, 1'b1, SRC_BT, 16'd35000);
        send_request(1'b0, 1'b1, SRC_BT, 16'd38000);
        send_request(1'b1, 1'b1, SRC_BT, 16'hFFFF);
        // draw nothing: other sources, and auto with no refresh due
        send_request(1'b1, 1'b1, SRC_OTHER, 16'hFFFF);
        send_request(1'b0, 1'b1, SRC_SPARE, 16'd5000);
        send_request(1'b1, 1'b0, SRC_AUX, 16'hFFFF);
        wait_idle();

        // flat modes ignore refresh_due and source
        write_mode(MODE_OFF);
        send_request(1'b1, 1'b0, SRC_SPARE, 16'hFFFF);
        wait_idle();
        write_mode(MODE_BLUE);
        send_request(1'b0, 1'b0, SRC_OTHER, 16'd0);
        wait_idle();
        // breathing: hold, then step twice
        write_mode(MODE_BREATH);
        send_request(1'b0, 1'b0, SRC_AUX, 16'd0);
        send_request(1'b1, 1'b1, SRC_BT, 16'hFFFF);
        send_request(1'b1, 1'b0, SRC_OTHER, 16'd100);
        wait_idle();
        // react and the unused codes all act as auto
        write_mode(MODE_REACT);
        send_request(1'b0, 1'b1, SRC_AUX, 16'd24999);
        send_request(1'b1, 1'b0, SRC_BT, 16'hFFFF);
        wait_idle();
        write_mode(MODE_SPARE7);
        send_request(1'b1, 1'b1, SRC_BT, 16'd300);
        wait_idle();
        write_mode(MODE_SPARE5);
        send_request(1'b0, 1'b1, SRC_AUX, 16'd12000);

        // Random part. Each phase drains first (the sender waits for every
        // expected word), then sets a mode and an idling style. The styles
        // are spread so each one meets a breathing phase; the first three also meet one acting as auto.
        for (p = 0; p < 12; p++)
        begin
            wait_idle();
            case (p)
                0, 11:      m = MODE_AUTO;
                1, 3, 5, 7: m = MODE_BREATH;
                2:          m = MODE_OFF;
                4:          m = MODE_REACT;
                6:          m = MODE_BLUE;
                8:          m = MODE_SPARE5;
                9:          m = MODE_SPARE6;
                default:    m = MODE_SPARE7;
            endcase
            write_mode(m);
            case ((p / 2) % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            send_random((m == MODE_BREATH) ? 53 : 12);
        end

        // drain, then give any stray word time to show up
        wait_idle();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lsm_pkg.sv
sv/lsm_front.sv
sv/lsm_cmd_fifo.sv
sv/lsm_back.sv
sv/led_strip_level_meter_encoder.sv
tb/lsm_tb_pkg.sv
tb/tb.sv
